FILE: rtl/lsbp_pkg.sv
// Shared types and constants of the LSB-first bit packer.
`timescale 1ns / 1ps

package lsbp_pkg;

  localparam int DEF_VALUE_WIDTH = 32;
  localparam int WIDTH_BITS      = 6;
  localparam int BYTE_BITS       = 8;
  localparam int JOB_BITS        = 32;
  localparam int PEND_BITS       = 7;
  localparam int CNT_BITS        = 3;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [WIDTH_BITS-1:0] BIT_WIDTH_RESET = 6'd8;
  localparam logic [WIDTH_BITS-1:0] W_BYTE          = 6'd8;
  localparam logic [WIDTH_BITS-1:0] W_HALF          = 6'd16;
  localparam logic [WIDTH_BITS-1:0] W_WORD          = 6'd32;

  // One request for the emitter: up to four bytes, LSB first.
  typedef struct packed {
    logic [JOB_BITS-1:0] data;
    logic [2:0]          count;
    logic                last;
    logic                err;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: rtl/lsbp_ifs.sv
// Valid/ready channel interfaces for values in and bytes out.
`timescale 1ns / 1ps

interface lsbp_in_if #(parameter int VALUE_WIDTH = 32);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic                   last_value;

  modport source (output valid, output value, output last_value, input ready);
  modport sink   (input valid, input value, input last_value, output ready);
endinterface

interface lsbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       run_end;
  logic       vector_end;
  logic       width_error;

  modport source (output valid, output packed_byte, output run_end,
                  output vector_end, output width_error, input ready);
  modport sink   (input valid, input packed_byte, input run_end,
                  input vector_end, input width_error, output ready);
endinterface

FILE: rtl/lsbp_front.sv
// Front end: width register, bit gathering and job building.
`timescale 1ns / 1ps

module lsbp_front
  import lsbp_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [WIDTH_BITS-1:0] cfg_wr_data,
  lsbp_in_if.sink               value_ch,
  input  queue_status_t         qstat,
  output logic                  push,
  output job_t                  push_job
);

  logic [WIDTH_BITS-1:0]  bit_width;
  logic [PEND_BITS-1:0]   pending_bits, pending_bits_next;
  logic [CNT_BITS-1:0]    pending_count, pending_count_next;

  logic [VALUE_WIDTH-1:0] raw;
  logic [JOB_BITS-1:0]    v;
  logic                   accept;
  logic                   narrow, aligned;
  logic [7:0]             mask;
  logic [PEND_BITS-1:0]   vm;
  logic [13:0]            acc;
  logic [3:0]             total, rem;
  logic                   full_byte, flush;

  assign raw            = value_ch.value;
  assign v              = JOB_BITS'(raw);
  assign value_ch.ready = !qstat.full;
  assign accept         = value_ch.valid && value_ch.ready;

  assign narrow  = (bit_width >= 6'd1) && (bit_width <= 6'd7);
  assign aligned = (bit_width == W_BYTE) || (bit_width == W_HALF) || (bit_width == W_WORD);

  always_comb begin
    mask      = (8'd1 << bit_width[2:0]) - 8'd1;
    vm        = v[PEND_BITS-1:0] & mask[PEND_BITS-1:0];
    acc       = {7'd0, pending_bits} | ({7'd0, vm} << pending_count);
    total     = {1'b0, pending_count} + bit_width[3:0];
    full_byte = total >= 4'd8;
    rem       = full_byte ? (total - 4'd8) : total;
    flush     = value_ch.last_value && (rem != 4'd0);

    push_job.last = value_ch.last_value;
    if (narrow) begin
      push_job.data  = {18'd0, acc};
      push_job.count = {2'b00, full_byte} + {2'b00, flush};
      push_job.err   = 1'b0;
      if (flush) begin
        pending_bits_next  = '0;
        pending_count_next = '0;
      end else if (full_byte) begin
        pending_bits_next  = {1'b0, acc[13:8]};
        pending_count_next = rem[2:0];
      end else begin
        pending_bits_next  = acc[PEND_BITS-1:0];
        pending_count_next = rem[2:0];
      end
    end else if (aligned) begin
      push_job.data      = v;
      push_job.count     = bit_width[5:3];
      push_job.err       = 1'b0;
      pending_bits_next  = '0;
      pending_count_next = '0;
    end else begin
      push_job.data      = '0;
      push_job.count     = 3'd1;
      push_job.err       = 1'b1;
      pending_bits_next  = '0;
      pending_count_next = '0;
    end
  end

  // narrow values that complete no byte and flush nothing make no request
  assign push = accept && (push_job.count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_width     <= BIT_WIDTH_RESET;
      pending_bits  <= '0;
      pending_count <= '0;
    end else begin
      if (cfg_wr_en) begin
        bit_width <= cfg_wr_data;
      end
      if (accept) begin
        pending_bits  <= pending_bits_next;
        pending_count <= pending_count_next;
      end
    end
  end

endmodule

FILE: rtl/lsbp_queue.sv
// Short request queue between front end and byte emitter.
`timescale 1ns / 1ps

module lsbp_queue
  import lsbp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  job_t          push_job,
  input  logic          pop,
  output job_t          pop_job,
  output queue_status_t qstat
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);

  job_t                 mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [FILL_BITS-1:0] fill;

  assign qstat.full  = fill == FILL_BITS'(QUEUE_DEPTH);
  assign qstat.empty = fill == '0;
  assign pop_job     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/lsbp_back.sv
// Emitter: walks each request into the output register one byte a cycle if ready.
`timescale 1ns / 1ps

module lsbp_back
  import lsbp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  queue_status_t qstat,
  input  job_t          pop_job,
  output logic          pop,
  lsbp_out_if.source    byte_ch
);

  logic [JOB_BITS-1:0] jdata;
  logic [2:0]          jleft;
  logic                jlast, jerr, jvalid;
  logic                load_out, final_byte;

  assign load_out   = jvalid && (!byte_ch.valid || byte_ch.ready);
  assign final_byte = load_out && (jleft == 3'd1);
  assign pop        = !qstat.empty && (!jvalid || final_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      jvalid        <= 1'b0;
      byte_ch.valid <= 1'b0;
    end else begin
      if (pop) begin
        jvalid <= 1'b1;
      end else if (final_byte) begin
        jvalid <= 1'b0;
      end
      if (load_out) begin
        byte_ch.valid <= 1'b1;
      end else if (byte_ch.ready) begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      jdata <= pop_job.data;
      jleft <= pop_job.count;
      jlast <= pop_job.last;
      jerr  <= pop_job.err;
    end else if (load_out) begin
      jdata <= jdata >> BYTE_BITS;
      jleft <= jleft - 3'd1;
    end
    if (load_out) begin
      byte_ch.packed_byte <= jdata[BYTE_BITS-1:0];
      byte_ch.run_end     <= jleft == 3'd1;
      byte_ch.vector_end  <= (jleft == 3'd1) && jlast;
      byte_ch.width_error <= jerr;
    end
  end

endmodule

FILE: rtl/lsb_first_bit_packer.sv
// Top level of the LSB-first variable-width bit packer.
// Packs each value at the configured width, LSB first, into a byte stream.
// Widths 1 to 7 gather bits across values and emit a byte per eight bits; a
// value flagged last_value flushes a partial byte with zero upper bits.
// Widths 8, 16 and 32 give one, two or four little-endian bytes per value;
// any other width gives a single zero byte with width_error set. The output
// channel carries one byte a cycle while the receiver is ready; a narrow
// value that completes no byte and flushes none makes no request. The
// front end takes a value every cycle while the two-entry request queue
// has room; a request passes the queue and the emitter's job register
// before its first byte reaches the output register. bit_width resets to
// 8, must be written only while the block is idle; nothing enforces it.
`timescale 1ns / 1ps

module lsb_first_bit_packer
  import lsbp_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [WIDTH_BITS-1:0] cfg_wr_data,
  lsbp_in_if.sink               value_ch,
  lsbp_out_if.source            byte_ch
);

  // request path front -> queue -> emitter
  job_t          push_job, pop_job;
  logic          push, pop;
  queue_status_t qstat;

  // front: holds bit_width and pending bits, one request per value at most
  lsbp_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .value_ch    (value_ch),
    .qstat       (qstat),
    .push        (push),
    .push_job    (push_job)
  );

  // queue: decouples acceptance from byte emission
  lsbp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .qstat    (qstat)
  );

  // back: one byte a cycle, while not stalled, into the registered output
  lsbp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .qstat   (qstat),
    .pop_job (pop_job),
    .pop     (pop),
    .byte_ch (byte_ch)
  );

endmodule

FILE: rtl/lsbp_checker.sv
// Port-level checks on the packer output, bound to the top level.
`timescale 1ns / 1ps

module lsbp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] packed_byte,
  input logic       run_end,
  input logic       vector_end,
  input logic       width_error
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output request dropped while stalled");

  a_vend_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && vector_end |-> run_end)
    else $error("vector_end without run_end");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && width_error |-> run_end && (packed_byte == 8'd0))
    else $error("error result not a lone zero byte");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind lsb_first_bit_packer lsbp_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (byte_ch.valid),
  .out_ready   (byte_ch.ready),
  .packed_byte (byte_ch.packed_byte),
  .run_end     (byte_ch.run_end),
  .vector_end  (byte_ch.vector_end),
  .width_error (byte_ch.width_error)
);

FILE: tb/lsb_first_bit_packer_tb.sv
// Self-checking testbench of the LSB-first bit packer: directed and random values.
`timescale 1ns / 1ps

module lsb_first_bit_packer_tb;
  import lsbp_pkg::*;

  localparam int VW            = 32;
  localparam int RANDOM_ITEMS  = 210;
  localparam int HOLD_CYCLES   = 150;  // long receiver hold-off
  localparam int SETTLE_CYCLES = 8;    // settle time once no bytes are expected
  localparam int TAIL_CYCLES   = 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;
  localparam int GAP_PCT       = 24;

  // Widths that the block must flag as errors.
  localparam logic [WIDTH_BITS-1:0] W_BAD_ZERO = 6'd0;
  localparam logic [WIDTH_BITS-1:0] W_BAD_NINE = 6'd9;
  localparam logic [WIDTH_BITS-1:0] W_BAD_OVER = 6'd33;
  localparam logic [WIDTH_BITS-1:0] W_BAD_MAX  = 6'd63;

  // One byte of the packed stream together with its flags.
  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic                 run_end;
    logic                 vector_end;
    logic                 width_error;
  } packed_byte_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en;
  logic [WIDTH_BITS-1:0] cfg_wr_data;

  lsbp_in_if #(.VALUE_WIDTH(VW)) value_in ();
  lsbp_out_if                    byte_out ();

  lsb_first_bit_packer #(.VALUE_WIDTH(VW)) uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .value_ch    (value_in),
    .byte_ch     (byte_out)
  );

  always #10 clk = ~clk;

  // Packer state as the testbench sees it: width register and held bits.
  logic [WIDTH_BITS-1:0] width_setting = BIT_WIDTH_RESET;
  logic [PEND_BITS-1:0]  held_bits     = '0;
  logic [CNT_BITS-1:0]   held_count    = '0;

  packed_byte_t expected_bytes[$];

  int  values_sent   = 0;
  int  bytes_checked = 0;
  int  mismatches    = 0;
  int  cycle_count   = 0;
  bit  src_gaps_on   = 1'b1;
  bit  sink_gaps_on  = 1'b1;
  int  hold_request  = 0;
  int  hold_served   = 0;
  int  hold_left     = 0;

  // Works out the bytes that one accepted value yields and queues them.
  function automatic void pack_value(input logic [VW-1:0] v, input logic last);
    packed_byte_t  res[4];
    int            n;
    logic [15:0]   acc;
    logic [15:0]   field;
    int unsigned   total;
    n = 0;
    if (width_setting >= 1 && width_setting <= 7) begin
      // narrow: mask stray upper bits, append above the held ones
      field = v[15:0] & ((16'd1 << width_setting) - 16'd1);
      acc   = {9'd0, held_bits} | (field << held_count);
      total = 32'(held_count) + 32'(width_setting);
      if (total >= BYTE_BITS) begin
        res[n] = '{data: acc[7:0], run_end: 1'b0, vector_end: 1'b0, width_error: 1'b0};
        n++;
        acc   = acc >> BYTE_BITS;
        total = total - BYTE_BITS;
      end
      if (last && total > 0) begin
        // flush the partial byte, upper bits already zero
        res[n] = '{data: acc[7:0], run_end: 1'b0, vector_end: 1'b0, width_error: 1'b0};
        n++;
        acc   = '0;
        total = 0;
      end
      held_bits  = acc[PEND_BITS-1:0];
      held_count = total[CNT_BITS-1:0];
    end else if (width_setting == W_BYTE || width_setting == W_HALF ||
                 width_setting == W_WORD) begin
      for (int k = 0; k < width_setting / BYTE_BITS; k++) begin
        res[n] = '{data: v[8*k +: 8], run_end: 1'b0, vector_end: 1'b0, width_error: 1'b0};
        n++;
      end
      held_bits  = '0;
      held_count = '0;
    end else begin
      // bad width: one zero byte with the error flag, value dropped
      res[n] = '{data: 8'h00, run_end: 1'b0, vector_end: 1'b0, width_error: 1'b1};
      n++;
      held_bits  = '0;
      held_count = '0;
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) begin
        res[i].run_end    = 1'b1;
        res[i].vector_end = last;
      end
      expected_bytes.push_back(res[i]);
    end
  endfunction

  // Offers one value, after a random gap if gaps are on, and leaves valid high once
  // the request is taken so that back-to-back requests need no dip.
  task automatic send_value(input logic [VW-1:0] v, input logic last);
    if (src_gaps_on) begin
      while ($urandom_range(99) < GAP_PCT) begin
        value_in.valid <= 1'b0;
        @(posedge clk);
      end
    end
    value_in.valid      <= 1'b1;
    value_in.value      <= v;
    value_in.last_value <= last;
    @(posedge clk);
    while (!value_in.ready) @(posedge clk);
    pack_value(v, last);
    values_sent++;
  endtask

  // Sender stops and waits until every expected byte has come.
  task automatic wait_until_idle();
    value_in.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    // a narrow value may leave no byte behind, so let the pipe settle
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_width(input logic [WIDTH_BITS-1:0] w);
    wait_until_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    width_setting  = w;
  endtask

  // Width 8 straight out of reset, no register write yet.
  task automatic test_reset_width();
    send_value('0, 1'b0);
    send_value('1, 1'b0);
    send_value(32'h5A5A_C3A5, 1'b1);
  endtask

  // Widths 1 to 7: gathering, flushing, stray upper bits and a width
  // change while bits are still held.
  task automatic test_narrow_widths();
    set_width(6'd3);
    send_value('1, 1'b0);               // stray upper bits must be masked
    send_value(32'h0000_0005, 1'b0);
    send_value(32'hFFFF_FFFA, 1'b1);    // full byte plus a one-bit flush
    set_width(6'd7);
    send_value(32'h0000_007F, 1'b0);    // seven bits, no byte yet
    send_value(32'h8000_0000, 1'b1);
    set_width(6'd4);
    send_value(32'h0000_000A, 1'b0);
    send_value(32'hFFFF_FFF5, 1'b1);    // last lands on a byte boundary
    set_width(6'd1);
    send_value(32'h0000_0001, 1'b0);
    send_value(32'h0000_0003, 1'b1);
    set_width(6'd5);
    send_value(32'h0000_001F, 1'b0);    // five bits held
    set_width(6'd2);                    // held bits survive the change
    send_value(32'h0000_0003, 1'b1);
  endtask

  task automatic test_wide_widths();
    set_width(W_HALF);
    send_value(32'h1234_ABCD, 1'b0);
    send_value(32'hFFFF_0000, 1'b1);
    set_width(W_WORD);
    send_value(32'h89AB_CDEF, 1'b1);
  endtask

  // Bad widths give one error byte and throw away any held bits.
  task automatic test_bad_widths();
    set_width(6'd5);
    send_value(32'h0000_001F, 1'b0);
    set_width(W_BAD_ZERO);
    send_value('1, 1'b1);
    set_width(W_BAD_NINE);
    send_value(32'h0000_0100, 1'b0);
    set_width(W_BAD_MAX);
    send_value(32'hDEAD_BEEF, 1'b0);
    set_width(W_BAD_OVER);
    send_value('0, 1'b1);
    set_width(6'd3);
    send_value(32'h0000_0007, 1'b1);    // held bits must be gone
  endtask

  // Receiver holds off while the sender keeps offering 32-bit values, so
  // the request queue fills and the input stalls; then the sender waits
  // for everything to drain.
  task automatic test_output_holdoff();
    set_width(W_WORD);
    src_gaps_on   = 1'b0;
    hold_request <= hold_request + 1;
    for (int i = 0; i < 16; i++) send_value($urandom, i == 15);
    src_gaps_on = 1'b1;
    wait_until_idle();
  endtask

  // Random phases: mostly narrow vectors ending in last_value, some aligned
  // and bad widths, some vectors cut short so bits carry into the next phase.
  task automatic test_random_vectors();
    logic [WIDTH_BITS-1:0] w;
    logic [VW-1:0]         v;
    int                    roll;
    int                    len;
    int                    sent;
    bit                    cut_short;
    bit                    quiet;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet         = (sent >= 90 && sent < 150);  // stretch with no random gaps
      src_gaps_on   = !quiet;
      sink_gaps_on <= !quiet;
      roll = $urandom_range(99);
      if (roll < 62)      w = WIDTH_BITS'($urandom_range(1, 7));
      else if (roll < 72) w = W_BYTE;
      else if (roll < 80) w = W_HALF;
      else if (roll < 90) w = W_WORD;
      else begin
        w = WIDTH_BITS'($urandom_range(9, 63));
        if (w == W_HALF || w == W_WORD) w = W_BAD_ZERO;
      end
      set_width(w);
      repeat ($urandom_range(1, 4)) begin
        len       = $urandom_range(1, 12);
        cut_short = ($urandom_range(99) < 15);
        for (int i = 0; i < len; i++) begin
          roll = $urandom_range(9);
          if (roll == 0)      v = '0;
          else if (roll == 1) v = '1;
          else                v = $urandom;
          send_value(v, (i == len - 1) && !cut_short);
          sent++;
        end
        if ($urandom_range(99) < 8) wait_until_idle();
      end
    end
    src_gaps_on   = 1'b1;
    sink_gaps_on <= 1'b1;
  endtask

  // Receiver: random ready, or a counted hold-off when one is asked for.
  always @(posedge clk) begin
    if (hold_request != hold_served) begin
      hold_served    <= hold_request;
      hold_left      <= HOLD_CYCLES;
      byte_out.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      byte_out.ready <= 1'b0;
    end else begin
      byte_out.ready <= !(sink_gaps_on && ($urandom_range(99) < GAP_PCT));
    end
  end

  // Every byte taken is checked against the oldest expectation.
  always @(posedge clk) begin : check_bytes
    packed_byte_t got;
    packed_byte_t want;
    if (!rst && byte_out.valid && byte_out.ready) begin
      got.data        = byte_out.packed_byte;
      got.run_end     = byte_out.run_end;
      got.vector_end  = byte_out.vector_end;
      got.width_error = byte_out.width_error;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: byte %02h run_end %b vector_end %b width_error %b with none expected",
                   $time, got.data, got.run_end, got.vector_end, got.width_error);
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: expected byte %02h re %b ve %b err %b, got byte %02h re %b ve %b err %b",
                     $time, want.data, want.run_end, want.vector_end, want.width_error,
                     got.data, got.run_end, got.vector_end, got.width_error);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected",
               cycle_count, expected_bytes.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    value_in.valid      = 1'b0;
    value_in.value      = '0;
    value_in.last_value = 1'b0;
    byte_out.ready      = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_width();
    test_narrow_widths();
    test_wide_widths();
    test_bad_widths();
    test_output_holdoff();
    test_random_vectors();

    wait_until_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d values and checked %0d bytes across widths 1 to 8, 16, 32",
             values_sent, bytes_checked);
    $display("and bad widths, with random gaps on both sides and a long output hold-off.");
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d bytes never seen", mismatches, expected_bytes.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lsbp_pkg.sv
rtl/lsbp_ifs.sv
rtl/lsbp_front.sv
rtl/lsbp_queue.sv
rtl/lsbp_back.sv
rtl/lsb_first_bit_packer.sv
rtl/lsbp_checker.sv
tb/lsb_first_bit_packer_tb.sv
